[src/bvp_pkg.sv]
// ----------------------------------------------------------------------------
// bvp_pkg
// Shared types, constants and helpers for the ball voxel painter: request and
// result payloads, effective configuration, and controller/datapath commands.
// ----------------------------------------------------------------------------
package bvp_pkg;

  // parameter defaults
  localparam int MAX_DIM_DEFAULT         = 512;
  localparam int COORD_FRAC_BITS_DEFAULT = 6;

  // fixed field widths
  localparam int DIM_W       = 10;
  localparam int SPACING_W   = 16;
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 16;
  localparam int ADDR_W      = 27;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = 2;

  localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_DEPTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING_X     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING_Y     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACING_Z     = 3'd5;

  // register reset values
  localparam logic [DIM_W-1:0]     DIM_RESET     = 10'd512;
  localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd256;

  // request action codes
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic        [RADIUS_W-1:0] ball_radius;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] voxel_address;
    logic              paint;
    logic              last;
  } result_t;

  // effective volume size and spacing, index 0 is x
  typedef struct packed {
    logic [NUM_AXES-1:0][DIM_W-1:0]     dim;
    logic [NUM_AXES-1:0][SPACING_W-1:0] spacing;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic              load_ball;
    logic              base;
    logic              div_init;
    logic              div_step;
    logic              div_first;
    logic              div_store;
    logic              side;
    logic [AXIS_W-1:0] axis;
    logic              measure;
    logic              sqr;
    logic              emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } ctrl_status_t;

  // bits of a box coordinate: volume sizes never exceed the register range
  function automatic int coord_width(input int max_dim);
    int w;
    w = $clog2(max_dim);
    if (w > DIM_W) w = DIM_W;
    return w;
  endfunction

endpackage

[src/bvp_ctrl.sv]
// ----------------------------------------------------------------------------
// bvp_ctrl
// Sequencer for the ball voxel painter: runs the bounding box divisions on a
// load and the two distance stages and the emit on a step, and tracks whether a
// scan is in progress.
// ----------------------------------------------------------------------------
module bvp_ctrl #(
  parameter int MAX_DIM = bvp_pkg::MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  bvp_pkg::request_t     request,
  input  bvp_pkg::ctrl_status_t status,
  output logic                  busy,
  output bvp_pkg::ctrl_cmd_t    cmd
);

  localparam int CW  = bvp_pkg::coord_width(MAX_DIM);
  localparam int BCW = $clog2(CW + 1);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_BASE      = 8'b0000_0010,
    S_DIV_INIT  = 8'b0000_0100,
    S_DIV_RUN   = 8'b0000_1000,
    S_DIV_STORE = 8'b0001_0000,
    S_DIST      = 8'b0010_0000,
    S_SQR       = 8'b0100_0000,
    S_EMIT      = 8'b1000_0000
  } state_t;

  state_t                          state, state_next;
  logic                            active, active_next;
  logic [bvp_pkg::AXIS_W-1:0]      axis, axis_next;
  logic                            side, side_next;
  logic [BCW-1:0]                  cnt, cnt_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next    = state;
    active_next   = active;
    axis_next     = axis;
    side_next     = side;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.axis      = axis;
    cmd.side      = side;
    cmd.div_first = (cnt == BCW'(CW));
    case (state)
      S_IDLE: begin
        if (start) begin
          if (request.action == bvp_pkg::ACTION_LOAD) begin
            active_next = 1'b0;
            if (request.ball_radius != '0) begin
              cmd.load_ball = 1'b1;
              axis_next     = bvp_pkg::AXIS_FIRST;
              side_next     = 1'b0;
              state_next    = S_BASE;
            end
          end else if (active) begin
            state_next = S_DIST;
          end
        end
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = BCW'(CW);
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DIV_STORE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (!side) begin
          side_next  = 1'b1;
          state_next = S_DIV_INIT;
        end else begin
          side_next = 1'b0;
          if (axis == bvp_pkg::AXIS_LAST) begin
            active_next = 1'b1;
            state_next  = S_IDLE;
          end else begin
            axis_next  = axis + 1'b1;
            state_next = S_BASE;
          end
        end
      end
      S_DIST: begin
        cmd.measure = 1'b1;
        state_next  = S_SQR;
      end
      S_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        if (status.last) active_next = 1'b0;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= 1'b0;
      axis   <= bvp_pkg::AXIS_FIRST;
      side   <= 1'b0;
      cnt    <= '0;
    end else begin
      state  <= state_next;
      active <= active_next;
      axis   <= axis_next;
      side   <= side_next;
      cnt    <= cnt_next;
    end
  end

  // a bound is stored only after the full quotient sweep
  a_store_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_STORE) |-> ($past(state) == S_DIV_RUN && $past(cnt) == '0))
    else $error("bound stored before division finished");

  // a step result comes out of the two distance stages
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ($past(state, 1) == S_SQR && $past(state, 2) == S_DIST))
    else $error("emit without distance stages");

  // step with no ball loaded is dropped
  a_idle_step_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && request.action == bvp_pkg::ACTION_STEP && !active)
    |=> (state == S_IDLE))
    else $error("step accepted without an active scan");

  // zero radius load stops the scan
  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && request.action == bvp_pkg::ACTION_LOAD &&
     request.ball_radius == '0) |=> (!active && state == S_IDLE))
    else $error("zero radius load did not stop the scan");

  // last bound stored starts the scan
  a_load_activates: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_STORE && side && axis == bvp_pkg::AXIS_LAST) |=> active)
    else $error("scan not active after load");

endmodule

[src/bvp_dp.sv]
// ----------------------------------------------------------------------------
// bvp_dp
// Datapath of the ball voxel painter: ball registers, bit-serial bounding box
// divider, scan position counters, three-lane distance pipeline and linear
// address computation.
// ----------------------------------------------------------------------------
module bvp_dp #(
  parameter int MAX_DIM         = bvp_pkg::MAX_DIM_DEFAULT,
  parameter int COORD_FRAC_BITS = bvp_pkg::COORD_FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bvp_pkg::request_t     request,
  input  bvp_pkg::cfg_t         cfg,
  input  bvp_pkg::ctrl_cmd_t    cmd,
  output bvp_pkg::ctrl_status_t status,
  output bvp_pkg::result_t      result,
  output logic                  done
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int CW   = bvp_pkg::coord_width(MAX_DIM);
  localparam int NA   = bvp_pkg::NUM_AXES;
  localparam int DW   = bvp_pkg::DIM_W;
  localparam int SPW  = bvp_pkg::SPACING_W;
  localparam int AW   = bvp_pkg::ADDR_W;
  // bound numerator 2*c*s -+ (8r + 5s)*2^F
  localparam int EW   = F + 20;
  localparam int NW   = ((EW > 32) ? EW : 32) + 2;
  localparam int DSW  = SPW + F + 1 + CW;
  localparam int RMW  = ((NW - 1) > DSW) ? (NW - 1) : DSW;
  // distance (v*2^F - c) * s
  localparam int DFW  = (((CW + F) > bvp_pkg::COORD_W) ? (CW + F) : bvp_pkg::COORD_W) + 2;
  localparam int PW   = DFW + SPW + 1;
  localparam int RSW  = 2 * bvp_pkg::RADIUS_W + 2 * F + 4;
  localparam int SW   = (RSW > 66) ? RSW : 66;

  // ball and box state
  logic signed [NA-1:0][bvp_pkg::COORD_W-1:0] center;
  logic [bvp_pkg::RADIUS_W-1:0]               radius;
  logic [2*bvp_pkg::RADIUS_W-1:0]             radius_sq;
  logic [NA-1:0][CW-1:0]                      box_lo, box_hi, pos;

  // divider state
  logic signed [NW-1:0] base;
  logic [EW-1:0]        ext;
  logic [RMW-1:0]       rem, dsh;
  logic [CW-1:0]        quot;
  logic                 sat;

  // distance pipeline
  logic signed [PW-1:0] dist_prod [NA];
  logic [63:0]          sq [NA];
  logic [NA-1:0]        big;
  logic [2*DW-1:0]      wh;
  logic [CW+DW-1:0]     yw;
  logic [AW-1:0]        zwh, yx;

  // axis selected for the load sequence
  logic signed [bvp_pkg::COORD_W-1:0] sel_center;
  logic [SPW-1:0]                     sel_spacing;
  logic [DW-1:0]                      sel_dim_m1;
  assign sel_center  = center[cmd.axis];
  assign sel_spacing = cfg.spacing[cmd.axis];
  assign sel_dim_m1  = cfg.dim[cmd.axis] - 1'b1;

  // center times spacing and box extension
  logic signed [SPW:0]          spacing_s;
  logic signed [SPW+bvp_pkg::COORD_W:0] cs_prod;
  logic [19:0]                  ext_sum;
  assign spacing_s = $signed({1'b0, sel_spacing});
  assign cs_prod   = sel_center * spacing_s;
  assign ext_sum   = 20'({radius, 3'b000}) + 20'(sel_spacing * 3'd5);

  // numerator for the selected side, only a positive one divides
  logic signed [NW-1:0] ext_s, num;
  logic                 rem_ge;
  assign ext_s  = NW'(ext);
  assign num    = cmd.side ? (base + ext_s) : (base - ext_s);
  assign rem_ge = (rem >= dsh);

  // truncated quotient clamped to the volume
  logic [CW-1:0] bound;
  always_comb begin
    if (sat || (DW'(quot) > sel_dim_m1)) begin
      bound = CW'(sel_dim_m1);
    end else begin
      bound = quot;
    end
  end

  // first lane stage: signed offset from the center
  logic signed [DFW-1:0] pos_f [NA];
  logic signed [DFW-1:0] cen_x [NA];
  logic signed [DFW-1:0] diff  [NA];
  logic signed [SPW:0]   spc_s [NA];
  logic [PW-1:0]         mag   [NA];
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      pos_f[a] = DFW'(pos[a]) << F;
      cen_x[a] = DFW'($signed(center[a]));
      diff[a]  = pos_f[a] - cen_x[a];
      spc_s[a] = $signed({1'b0, cfg.spacing[a]});
      mag[a]   = dist_prod[a][PW-1] ? PW'(-dist_prod[a]) : PW'(dist_prod[a]);
    end
  end

  // inside test against the scaled radius
  logic [SW-1:0] r2s, sq_sum;
  logic          paint_now, last_hit;
  always_comb begin
    r2s       = SW'(radius_sq) << (2 * F + 4);
    sq_sum    = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    paint_now = (big == '0) && (sq_sum <= r2s);
    for (int a = 0; a < NA; a++) begin
      if (SW'(sq[a]) > r2s) paint_now = 1'b0;
    end
  end

  assign last_hit    = (pos[0] == box_hi[0]) && (pos[1] == box_hi[1]) &&
                       (pos[2] == box_hi[2]);
  assign status.last = last_hit;

  // ball registers and divider
  always_ff @(posedge clk) begin
    if (cmd.load_ball) begin
      center[0] <= request.center_x;
      center[1] <= request.center_y;
      center[2] <= request.center_z;
      radius    <= request.ball_radius;
      radius_sq <= request.ball_radius * request.ball_radius;
    end
    if (cmd.base) begin
      base <= NW'(cs_prod) <<< 1;
      ext  <= EW'(ext_sum) << F;
    end
    if (cmd.div_init) begin
      rem  <= (num > 0) ? RMW'(num[NW-2:0]) : '0;
      dsh  <= RMW'(sel_spacing) << (F + 1 + CW);
      quot <= '0;
      sat  <= 1'b0;
    end
    if (cmd.div_step) begin
      if (cmd.div_first) begin
        if (rem_ge) sat <= 1'b1;
      end else begin
        if (rem_ge) rem <= rem - dsh;
        quot <= (quot << 1) | CW'(rem_ge);
      end
      dsh <= dsh >> 1;
    end
    if (cmd.div_store) begin
      if (cmd.side) begin
        box_hi[cmd.axis] <= bound;
      end else begin
        box_lo[cmd.axis] <= bound;
        pos[cmd.axis]    <= bound;
      end
    end
    // scan order x fastest, then y, then z
    if (cmd.emit && !last_hit) begin
      if (pos[0] < box_hi[0]) begin
        pos[0] <= pos[0] + 1'b1;
      end else begin
        pos[0] <= box_lo[0];
        if (pos[1] < box_hi[1]) begin
          pos[1] <= pos[1] + 1'b1;
        end else begin
          pos[1] <= box_lo[1];
          pos[2] <= pos[2] + 1'b1;
        end
      end
    end
  end

  // distance lanes and address
  always_ff @(posedge clk) begin
    if (cmd.measure) begin
      for (int a = 0; a < NA; a++) begin
        dist_prod[a] <= diff[a] * spc_s[a];
      end
      wh <= cfg.dim[0] * cfg.dim[1];
      yw <= pos[1] * cfg.dim[0];
    end
    if (cmd.sqr) begin
      for (int a = 0; a < NA; a++) begin
        big[a] <= (mag[a] > (PW'(1) << 31));
        sq[a]  <= mag[a][31:0] * mag[a][31:0];
      end
      zwh <= AW'(pos[2] * wh);
      yx  <= AW'(yw) + AW'(pos[0]);
    end
    if (cmd.emit) begin
      result.voxel_address <= zwh + yx;
      result.paint         <= paint_now;
      result.last          <= last_hit;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

[src/ball_voxel_painter.sv]
// Step request: taken only while idle, then two distance stages and an emit that
// registers the result and its done strobe; a new request waits for that emit.
// Load request: busy while the bit-serial box divider finds two bounds per axis,
// CW+1 quotient steps each, with CW = min(clog2(MAX_DIM), 10).
// Zero radius load and a step with no ball loaded give no result and no busy.
// Synchronous reset stops any scan and restores the register defaults.
// ----------------------------------------------------------------------------
// ball_voxel_painter
// Paints a ball into a voxel volume: a load request sets up the ball and its
// clamped bounding box, each step request scans one box voxel and returns its
// address with paint and last flags.
// ----------------------------------------------------------------------------
module ball_voxel_painter #(
  parameter int MAX_DIM         = bvp_pkg::MAX_DIM_DEFAULT,
  parameter int COORD_FRAC_BITS = bvp_pkg::COORD_FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bvp_pkg::request_t                   request,
  output bvp_pkg::result_t                    result,
  output logic                                done,
  input  logic                                cfg_we,
  input  logic [bvp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bvp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NA  = bvp_pkg::NUM_AXES;
  localparam int DW  = bvp_pkg::DIM_W;
  localparam int SPW = bvp_pkg::SPACING_W;

  logic [NA-1:0][DW-1:0]  dim_reg;
  logic [NA-1:0][SPW-1:0] spacing_reg;
  bvp_pkg::cfg_t          cfg;
  bvp_pkg::ctrl_cmd_t     cmd;
  bvp_pkg::ctrl_status_t  status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg     <= {NA{bvp_pkg::DIM_RESET}};
      spacing_reg <= {NA{bvp_pkg::SPACING_RESET}};
    end else if (cfg_we) begin
      case (cfg_index)
        bvp_pkg::REG_VOLUME_WIDTH:  dim_reg[0]     <= cfg_data[DW-1:0];
        bvp_pkg::REG_VOLUME_HEIGHT: dim_reg[1]     <= cfg_data[DW-1:0];
        bvp_pkg::REG_VOLUME_DEPTH:  dim_reg[2]     <= cfg_data[DW-1:0];
        bvp_pkg::REG_SPACING_X:     spacing_reg[0] <= cfg_data[SPW-1:0];
        bvp_pkg::REG_SPACING_Y:     spacing_reg[1] <= cfg_data[SPW-1:0];
        bvp_pkg::REG_SPACING_Z:     spacing_reg[2] <= cfg_data[SPW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes 1..MAX_DIM, zero spacing reads as one
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (dim_reg[a] == '0) begin
        cfg.dim[a] = DW'(1);
      end else if (32'(dim_reg[a]) > MAX_DIM) begin
        cfg.dim[a] = DW'(MAX_DIM);
      end else begin
        cfg.dim[a] = dim_reg[a];
      end
      cfg.spacing[a] = (spacing_reg[a] == '0) ? SPW'(1) : spacing_reg[a];
    end
  end

  bvp_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  bvp_dp #(
    .MAX_DIM         (MAX_DIM),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .done    (done)
  );

endmodule
